// File: rtl/vsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vsa_pkg;

    // Field widths of the stream items
    localparam int SLOT_W   = 5;
    localparam int CH_W     = 4;
    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 7;
    localparam int KEY_W    = CH_W + NOTE_W;
    localparam int SIZE_W   = 3;
    localparam int OP_W     = 2;
    localparam int ACT_W    = 2;

    // Packed tdata widths, padded to whole bytes
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // Reset value of the table size register
    localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd5;

    typedef enum logic [OP_W-1:0] {
        OP_NOTE_ON    = 2'd0,
        OP_NOTE_OFF   = 2'd1,
        OP_VOICE_DONE = 2'd2
    } t_opcode;

    typedef enum logic [ACT_W-1:0] {
        ACT_RELEASE   = 2'd0,
        ACT_START     = 2'd1,
        ACT_FULL      = 2'd2,
        ACT_NOT_FOUND = 2'd3
    } t_action;

    // Verdict of the shared probe compare on one slot
    typedef struct packed {
        logic free;
        logic hit;
    } t_probe;

endpackage

`default_nettype wire

// File: rtl/vsa_key_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module vsa_key_ram
    import vsa_pkg::*;
#(
    parameter int ADDR_W = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [KEY_W-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [KEY_W-1:0]  o_rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [KEY_W-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/vsa_probe.sv
`timescale 1ns / 1ps
`default_nettype none

module vsa_probe
    import vsa_pkg::*;
#(
    parameter int ADDR_W = 5
) (
    input  wire logic [ADDR_W-1:0] i_home,
    input  wire logic [ADDR_W-1:0] i_idx,
    input  wire logic [ADDR_W-1:0] i_mask,
    input  wire logic [KEY_W-1:0]  i_want,
    input  wire logic [KEY_W-1:0]  i_key,
    input  wire logic              i_busy,
    input  wire logic              i_held,
    output logic      [ADDR_W-1:0] o_addr,
    output t_probe                 o_probe
);

    // Step from home, wrap at the table size
    assign o_addr = (i_home + i_idx) & i_mask;

    // A held slot matches only on the full channel and note key
    assign o_probe.free = !i_busy;
    assign o_probe.hit  = i_held && (i_key == i_want);

endmodule

`default_nettype wire

// File: rtl/voice_slot_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Voice slot allocator: a polyphonic voice table with linear probing.
// Requests arrive on the s_axis stream (tuser = opcode), results leave on
// the m_axis stream (tuser = action, tlast on the final result of a
// request). The table size register is written on the cfg channel, which
// is always ready; write it only while no request is in flight.
// A voice-done request produces no result.
// A note-on or note-off walks the table one slot per probe; each probe
// passes through a read state and a check state because the key store is
// a single memory with a registered read feeding one shared compare unit.
// A note-on walk ends at a free slot and a note-off walk at a matching
// slot; a walk that covers the whole table ends in a final state with the
// table-full or not-found result. s_axis_tready is high only between
// requests and returns in the cycle after the final result loads, so a
// note request cannot be taken until the walk of the last one ends;
// voice-done requests are taken every cycle while no walk is in progress.
// Results sit in an output register; when the receiver stalls the walk
// holds at the slot that wants to emit. A request can be taken while the
// last result of the previous one still waits.
// Reset frees every slot and sets the table to 2^5 slots; the key store
// is not cleared since only busy slots are ever compared.

module voice_slot_allocator
    import vsa_pkg::*;
#(
    parameter int MAX_SLOT_BITS = 5
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // request stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: channel[3:0], note_key[10:4], velocity[17:11], done_slot[22:18]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: opcode[1:0]
    input  wire logic [OP_W-1:0]        s_axis_tuser,
    // result stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata: slot[4:0], out_channel[8:5], out_key[15:9], out_velocity[22:16]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: action[1:0]
    output logic [ACT_W-1:0]            m_axis_tuser,
    output logic                        m_axis_tlast,
    // table size register write
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [SIZE_W-1:0]      i_cfg_data
);

    localparam int AW    = MAX_SLOT_BITS;
    localparam int SLOTS = 1 << AW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FINAL
    } t_state;

    t_state             r_state;
    logic [SIZE_W-1:0]  r_size;
    logic [SLOTS-1:0]   r_busy;
    logic [SLOTS-1:0]   r_held;
    logic [OP_W-1:0]    r_op;
    logic [KEY_W-1:0]   r_want;
    logic [VEL_W-1:0]   r_vel;
    logic [AW-1:0]      r_home;
    logic [AW-1:0]      r_mask;
    logic [AW-1:0]      r_idx;
    logic [AW-1:0]      r_slot;

    logic               r_out_valid;
    t_action            r_out_action;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [KEY_W-1:0]   r_out_key;
    logic [VEL_W-1:0]   r_out_vel;
    logic               r_out_last;

    logic [CH_W-1:0]    in_ch;
    logic [NOTE_W-1:0]  in_note;
    logic [VEL_W-1:0]   in_vel;
    logic [SLOT_W-1:0]  in_done;
    logic [SIZE_W-1:0]  size_sat;
    logic [AW:0]        mask_full;
    logic [NOTE_W:0]    home_sum;
    logic               in_xfer;
    logic               done_in_range;

    logic [AW-1:0]      probe_addr;
    logic [KEY_W-1:0]   rd_key;
    t_probe             probe;

    logic               out_free;
    logic               do_start;
    logic               do_release;
    logic               do_pass;
    logic               do_final;
    logic               advance;
    logic               load_out;

    t_action            n_action;
    logic [SLOT_W-1:0]  n_slot;
    logic [VEL_W-1:0]   n_vel;
    logic               n_last;

    // Unpack the request fields
    assign in_ch   = s_axis_tdata[3:0];
    assign in_note = s_axis_tdata[10:4];
    assign in_vel  = s_axis_tdata[17:11];
    assign in_done = s_axis_tdata[22:18];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Table size: saturate, then build the wrap mask and the home slot
    assign size_sat  = (r_size > SIZE_W'(MAX_SLOT_BITS)) ? SIZE_W'(MAX_SLOT_BITS) : r_size;
    assign mask_full = ((AW + 1)'(1) << size_sat) - (AW + 1)'(1);
    assign home_sum  = (NOTE_W + 1)'(in_ch) + (NOTE_W + 1)'(in_note);
    assign done_in_range = (SLOT_W'(in_done[AW-1:0]) == in_done);

    vsa_probe #(
        .ADDR_W (AW)
    ) u_probe (
        .i_home  (r_home),
        .i_idx   (r_idx),
        .i_mask  (r_mask),
        .i_want  (r_want),
        .i_key   (rd_key),
        .i_busy  (r_busy[r_slot]),
        .i_held  (r_held[r_slot]),
        .o_addr  (probe_addr),
        .o_probe (probe)
    );

    vsa_key_ram #(
        .ADDR_W (AW)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (do_start),
        .i_wr_addr (r_slot),
        .i_wr_data (r_want),
        .i_rd_en   (r_state == ST_READ),
        .i_rd_addr (probe_addr),
        .o_rd_data (rd_key)
    );

    // Decide what the current probe does
    always_comb begin
        out_free   = !r_out_valid || m_axis_tready;
        do_start   = (r_state == ST_CHECK) && (r_op == OP_NOTE_ON) && probe.free && out_free;
        do_release = (r_state == ST_CHECK) && probe.hit && out_free;
        do_pass    = (r_state == ST_CHECK) && !probe.hit
                     && !((r_op == OP_NOTE_ON) && probe.free);
        do_final   = (r_state == ST_FINAL) && out_free;
        advance    = do_pass || (do_release && (r_op == OP_NOTE_ON));
        load_out   = do_start || do_release || do_final;
    end

    // Select the result to load
    always_comb begin
        n_action = ACT_RELEASE;
        n_slot   = SLOT_W'(r_slot);
        n_vel    = '0;
        n_last   = 1'b0;
        if (do_start) begin
            n_action = ACT_START;
            n_vel    = r_vel;
            n_last   = 1'b1;
        end else if (do_release) begin
            n_last   = (r_op == OP_NOTE_OFF);
        end else begin
            n_action = (r_op == OP_NOTE_ON) ? ACT_FULL : ACT_NOT_FOUND;
            n_slot   = SLOT_W'(r_home);
            n_last   = 1'b1;
        end
    end

    // Sequencer, slot flags and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_size      <= SIZE_RESET;
            r_busy      <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_size <= i_cfg_data;
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        case (s_axis_tuser)
                            OP_NOTE_ON, OP_NOTE_OFF: r_state <= ST_READ;
                            OP_VOICE_DONE: begin
                                if (done_in_range) begin
                                    r_busy[in_done[AW-1:0]] <= 1'b0;
                                    r_held[in_done[AW-1:0]] <= 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_READ: begin
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (do_start) begin
                        r_busy[r_slot] <= 1'b1;
                        r_held[r_slot] <= 1'b1;
                        r_state        <= ST_IDLE;
                    end else if (do_release) begin
                        r_held[r_slot] <= 1'b0;
                    end
                    if (do_release && (r_op == OP_NOTE_OFF)) begin
                        r_state <= ST_IDLE;
                    end else if (advance) begin
                        r_state <= (r_idx == r_mask) ? ST_FINAL : ST_READ;
                    end
                end
                ST_FINAL: begin
                    if (do_final) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Request context, probe index and result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op   <= s_axis_tuser;
            r_want <= {in_ch, in_note};
            r_vel  <= in_vel;
            r_mask <= mask_full[AW-1:0];
            r_home <= home_sum[AW-1:0] & mask_full[AW-1:0];
            r_idx  <= '0;
        end else if (advance && (r_idx != r_mask)) begin
            r_idx  <= r_idx + AW'(1);
        end
        if (r_state == ST_READ) begin
            r_slot <= probe_addr;
        end
        if (load_out) begin
            r_out_action <= n_action;
            r_out_slot   <= n_slot;
            r_out_key    <= r_want;
            r_out_vel    <= n_vel;
            r_out_last   <= n_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_action;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {1'b0, r_out_vel, r_out_key[NOTE_W-1:0],
                            r_out_key[KEY_W-1:NOTE_W], r_out_slot};

endmodule

`default_nettype wire

// File: rtl/vsa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module vsa_checker
    import vsa_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [OP_W-1:0]        s_axis_tuser,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [ACT_W-1:0]       m_axis_tuser,
    input wire logic                   m_axis_tlast
);

    // Accepting a note request closes the request side
    a_busy_after_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready
         && (s_axis_tuser == OP_NOTE_ON || s_axis_tuser == OP_NOTE_OFF))
        |=> !s_axis_tready)
        else $error("request side open during a walk");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("stalled result changed");

    // Only a start carries a velocity
    a_vel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ACT_START) |-> (m_axis_tdata[22:16] == '0))
        else $error("velocity on a non-start result");

    // Start, table full and not found always end a request
    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ACT_START || m_axis_tuser == ACT_FULL
                           || m_axis_tuser == ACT_NOT_FOUND))
        |-> m_axis_tlast)
        else $error("final result without tlast");

endmodule

bind voice_slot_allocator vsa_checker u_vsa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
